// File: sv/mbcf_pkg.sv
`timescale 1ns / 1ps

package mbcf_pkg;

  // Field widths
  localparam int TIME_W    = 31;
  localparam int RING_W    = 10;
  localparam int SLOT_W    = 16;
  localparam int VERDICT_W = 2;

  // Configuration register widths
  localparam int CYCLE_W = 8;
  localparam int BED_W   = 8;
  localparam int FRING_W = 11;
  localparam int WIN_W   = 11;
  localparam int OVL_W   = 10;
  localparam int SECS_W  = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = TIME_W;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_TIME    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_COUNT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BED_COUNT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_RING    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RINGS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_RINGS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_SECONDS  = 3'd6;

  // Verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_KEEP = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_LATE = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_RING = 2'd2;

  localparam logic [SLOT_W-1:0] SLOT_MAX = '1;

  // Derived widths
  localparam int TOTAL_W = BED_W + CYCLE_W;        // beds * cycles
  localparam int STEP_W  = WIN_W + 1;              // signed bed step
  localparam int OFFS_W  = BED_W + 1 + STEP_W;     // signed bed * step
  localparam int BOUND_W = OFFS_W + 2;             // signed window bounds
  localparam int DIVD_W  = TIME_W + 1;             // signed elapsed time

  // Slot divider: quotient bits resolved per stage
  localparam int SDIV_PER_STAGE = 2;
  localparam int SDIV_STAGES    = DIVD_W / SDIV_PER_STAGE;

  // Bed remainder: quotient is below cycle_count, so CYCLE_W bits
  localparam int BQ_W           = CYCLE_W;
  localparam int BDIV_PER_STAGE = 2;
  localparam int BDIV_STAGES    = BQ_W / BDIV_PER_STAGE;

  typedef struct packed {
    logic [TIME_W-1:0]         first_time;
    logic [CYCLE_W-1:0]        cycle_count;
    logic [BED_W-1:0]          bed_count;
    logic [FRING_W-1:0]        first_ring;
    logic [WIN_W-1:0]          window_rings;
    logic [OVL_W-1:0]          overlap_rings;
    logic [SECS_W-1:0]         slot_seconds;
    logic [TOTAL_W-1:0]        total;      // bed_count * cycle_count
    logic signed [STEP_W-1:0]  bed_step;   // window_rings - overlap_rings
  } cfg_t;

  // Slot divider result
  typedef struct packed {
    logic [RING_W-1:0] ring_a;
    logic [RING_W-1:0] ring_b;
    logic              no_end;    // zero slot length, non-negative elapsed
    logic [DIVD_W-1:0] quotient;
  } quo_t;

  // Bed remainder result
  typedef struct packed {
    logic [RING_W-1:0] ring_a;
    logic [RING_W-1:0] ring_b;
    logic              late;      // slot past the last one
    logic [SLOT_W-1:0] slot;      // saturated slot
    logic [BED_W-1:0]  bed;
  } bed_t;

endpackage

// File: sv/mbcf_event_if.sv
`timescale 1ns / 1ps

interface mbcf_event_if import mbcf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RING_W-1:0] ring_a;
  logic [RING_W-1:0] ring_b;
  logic [TIME_W-1:0] event_time;

  modport source (output valid, ring_a, ring_b, event_time, input ready);
  modport sink   (input valid, ring_a, ring_b, event_time, output ready);
endinterface

// File: sv/mbcf_result_if.sv
`timescale 1ns / 1ps

interface mbcf_result_if import mbcf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 keep;
  logic [VERDICT_W-1:0] verdict;
  logic [SLOT_W-1:0]    slot;

  modport source (output valid, keep, verdict, slot, input ready);
  modport sink   (input valid, keep, verdict, slot, output ready);
endinterface

// File: sv/mbcf_cfg_regs.sv
`timescale 1ns / 1ps

module mbcf_cfg_regs
  import mbcf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  // Register writes; unknown indexes are dropped.
  // Derived values are registered from the fields, so they follow in the cycle after a field write.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_time    <= '0;
      cfg.cycle_count   <= CYCLE_W'(1);
      cfg.bed_count     <= BED_W'(1);
      cfg.first_ring    <= FRING_W'(1);
      cfg.window_rings  <= WIN_W'(1024);
      cfg.overlap_rings <= '0;
      cfg.slot_seconds  <= SECS_W'(60);
      cfg.total         <= TOTAL_W'(1);
      cfg.bed_step      <= STEP_W'(1024);
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_FIRST_TIME:    cfg.first_time    <= wr_data[TIME_W-1:0];
          REG_CYCLE_COUNT:   cfg.cycle_count   <= wr_data[CYCLE_W-1:0];
          REG_BED_COUNT:     cfg.bed_count     <= wr_data[BED_W-1:0];
          REG_FIRST_RING:    cfg.first_ring    <= wr_data[FRING_W-1:0];
          REG_WINDOW_RINGS:  cfg.window_rings  <= wr_data[WIN_W-1:0];
          REG_OVERLAP_RINGS: cfg.overlap_rings <= wr_data[OVL_W-1:0];
          REG_SLOT_SECONDS:  cfg.slot_seconds  <= wr_data[SECS_W-1:0];
          default: ;
        endcase
      end
      cfg.total    <= TOTAL_W'(cfg.bed_count) * TOTAL_W'(cfg.cycle_count);
      cfg.bed_step <= $signed({1'b0, cfg.window_rings})
                      - $signed(STEP_W'(cfg.overlap_rings));
    end
  end

endmodule

// File: sv/mbcf_slot_div.sv
`timescale 1ns / 1ps

module mbcf_slot_div
  import mbcf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [RING_W-1:0] in_ring_a,
  input  logic [RING_W-1:0] in_ring_b,
  input  logic [TIME_W-1:0] in_time,
  input  cfg_t              cfg,
  output logic              out_valid,
  input  logic              out_ready,
  output quo_t              out_data
);

  logic [SDIV_STAGES:0]   valid;
  logic [SDIV_STAGES+1:0] ready;
  logic [SECS_W-1:0]      rem    [0:SDIV_STAGES];
  logic [DIVD_W-1:0]      dq     [0:SDIV_STAGES];
  logic [RING_W-1:0]      ring_a [0:SDIV_STAGES];
  logic [RING_W-1:0]      ring_b [0:SDIV_STAGES];
  logic                   no_end [0:SDIV_STAGES];
  logic [DIVD_W-1:0]      elapsed;

  // A stage takes a new item when empty or when its successor moves
  assign ready[SDIV_STAGES+1] = out_ready;
  for (genvar s = 0; s <= SDIV_STAGES; s++) begin : g_ready
    assign ready[s] = !valid[s] || ready[s+1];
  end
  assign in_ready = ready[0];

  // Entry stage: elapsed time, clamped at zero when negative
  assign elapsed = {1'b0, in_time} - {1'b0, cfg.first_time};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (ready[0]) begin
      valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready[0] && in_valid) begin
      dq[0]     <= elapsed[DIVD_W-1] ? '0 : elapsed;
      rem[0]    <= '0;
      no_end[0] <= !elapsed[DIVD_W-1] && (cfg.slot_seconds == '0);
      ring_a[0] <= in_ring_a;
      ring_b[0] <= in_ring_b;
    end
  end

  // Restoring division: dividend bits shift out of dq, quotient bits in.
  // A zero divisor never subtracts, so a clamped dividend stays slot zero.
  for (genvar s = 1; s <= SDIV_STAGES; s++) begin : g_stage
    logic [SECS_W-1:0] rem_next;
    logic [DIVD_W-1:0] dq_next;
    logic [SECS_W+1:0] trial;
    logic              take;

    always_comb begin
      rem_next = rem[s-1];
      dq_next  = dq[s-1];
      trial    = '0;
      take     = 1'b0;
      for (int k = 0; k < SDIV_PER_STAGE; k++) begin
        trial = {1'b0, rem_next, dq_next[DIVD_W-1]} - {2'b00, cfg.slot_seconds};
        take  = !trial[SECS_W+1] && (cfg.slot_seconds != '0);
        if (take) begin
          rem_next = trial[SECS_W-1:0];
        end else begin
          rem_next = {rem_next[SECS_W-2:0], dq_next[DIVD_W-1]};
        end
        dq_next = {dq_next[DIVD_W-2:0], take};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[s] <= 1'b0;
      end else if (ready[s]) begin
        valid[s] <= valid[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ready[s] && valid[s-1]) begin
        rem[s]    <= rem_next;
        dq[s]     <= dq_next;
        no_end[s] <= no_end[s-1];
        ring_a[s] <= ring_a[s-1];
        ring_b[s] <= ring_b[s-1];
      end
    end
  end

  assign out_valid         = valid[SDIV_STAGES];
  assign out_data.ring_a   = ring_a[SDIV_STAGES];
  assign out_data.ring_b   = ring_b[SDIV_STAGES];
  assign out_data.no_end   = no_end[SDIV_STAGES];
  assign out_data.quotient = dq[SDIV_STAGES];

`ifndef SYNTHESIS
  // Dividend is below 2^31, so a real quotient never sets its top bit
  a_quo_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.no_end |-> !out_data.quotient[DIVD_W-1])
    else $error("slot quotient out of range");

  // Remainder stays below a nonzero divisor
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.no_end && (cfg.slot_seconds != '0)
    |-> rem[SDIV_STAGES] < cfg.slot_seconds)
    else $error("slot remainder not below slot length");

  // A stalled entry stage keeps its item
  a_entry_hold: assert property (@(posedge clk) disable iff (rst)
    valid[0] && !ready[0] |=> valid[0] && $stable(dq[0]))
    else $error("entry stage dropped a stalled item");
`endif

endmodule

// File: sv/mbcf_bed_div.sv
`timescale 1ns / 1ps

module mbcf_bed_div
  import mbcf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  quo_t in_data,
  input  cfg_t cfg,
  output logic out_valid,
  input  logic out_ready,
  output bed_t out_data
);

  logic [BDIV_STAGES:0]   valid;
  logic [BDIV_STAGES+1:0] ready;
  logic [TOTAL_W-1:0]     rem    [0:BDIV_STAGES];
  logic [RING_W-1:0]      ring_a [0:BDIV_STAGES];
  logic [RING_W-1:0]      ring_b [0:BDIV_STAGES];
  logic                   late   [0:BDIV_STAGES];
  logic [SLOT_W-1:0]      slot   [0:BDIV_STAGES];
  logic [DIVD_W-1:0]      slot_full;
  logic [DIVD_W-1:0]      total_ext;

  assign ready[BDIV_STAGES+1] = out_ready;
  for (genvar s = 0; s <= BDIV_STAGES; s++) begin : g_ready
    assign ready[s] = !valid[s] || ready[s+1];
  end
  assign in_ready = ready[0];

  // Entry stage: final slot, past-last test, saturation
  assign total_ext = DIVD_W'(cfg.total);
  assign slot_full = in_data.no_end ? total_ext : in_data.quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (ready[0]) begin
      valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready[0] && in_valid) begin
      late[0]   <= slot_full >= total_ext;
      slot[0]   <= (|slot_full[DIVD_W-1:SLOT_W]) ? SLOT_MAX : slot_full[SLOT_W-1:0];
      rem[0]    <= slot_full[TOTAL_W-1:0];
      ring_a[0] <= in_data.ring_a;
      ring_b[0] <= in_data.ring_b;
    end
  end

  // slot mod bed_count: quotient is below cycle_count when in range
  for (genvar s = 1; s <= BDIV_STAGES; s++) begin : g_stage
    logic [TOTAL_W-1:0] rem_next;
    logic [TOTAL_W-1:0] sub;

    always_comb begin
      rem_next = rem[s-1];
      sub      = '0;
      for (int k = 0; k < BDIV_PER_STAGE; k++) begin
        sub = TOTAL_W'(cfg.bed_count) << (BQ_W - 1 - (s - 1) * BDIV_PER_STAGE - k);
        if (rem_next >= sub) begin
          rem_next = rem_next - sub;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[s] <= 1'b0;
      end else if (ready[s]) begin
        valid[s] <= valid[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ready[s] && valid[s-1]) begin
        rem[s]    <= rem_next;
        late[s]   <= late[s-1];
        slot[s]   <= slot[s-1];
        ring_a[s] <= ring_a[s-1];
        ring_b[s] <= ring_b[s-1];
      end
    end
  end

  assign out_valid       = valid[BDIV_STAGES];
  assign out_data.ring_a = ring_a[BDIV_STAGES];
  assign out_data.ring_b = ring_b[BDIV_STAGES];
  assign out_data.late   = late[BDIV_STAGES];
  assign out_data.slot   = slot[BDIV_STAGES];
  assign out_data.bed    = rem[BDIV_STAGES][BED_W-1:0];

`ifndef SYNTHESIS
  // In range, the remainder ends below bed_count
  a_bed_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.late |-> rem[BDIV_STAGES] < TOTAL_W'(cfg.bed_count))
    else $error("bed index not below bed count");

  // In range, the slot is below beds times cycles
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.late |-> out_data.slot < cfg.total)
    else $error("in-range slot not below slot total");

  // No slot at all means every item is past the last slot
  a_no_slots: assert property (@(posedge clk) disable iff (rst)
    out_valid && cfg.total == '0 |-> out_data.late)
    else $error("item kept in range with no slots configured");
`endif

endmodule

// File: sv/mbcf_window.sv
`timescale 1ns / 1ps

module mbcf_window
  import mbcf_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bed_t          in_data,
  input  cfg_t          cfg,
  mbcf_result_if.source results
);

  logic                      v_mul;
  logic                      v_bnd;
  logic                      v_out;
  logic                      rdy_mul;
  logic                      rdy_bnd;
  logic                      rdy_out;

  logic signed [OFFS_W-1:0]  offs;
  logic signed [OFFS_W-1:0]  offs_next;
  logic                      late_mul;
  logic [SLOT_W-1:0]         slot_mul;
  logic [RING_W-1:0]         ring_a_mul;
  logic [RING_W-1:0]         ring_b_mul;

  logic signed [BOUND_W-1:0] lo;
  logic signed [BOUND_W-1:0] hi;
  logic signed [BOUND_W-1:0] lo_next;
  logic signed [BOUND_W-1:0] hi_next;
  logic signed [BOUND_W-1:0] ra1;
  logic signed [BOUND_W-1:0] rb1;
  logic                      late_bnd;
  logic [SLOT_W-1:0]         slot_bnd;
  logic                      in_win;

  logic                      keep;
  logic [VERDICT_W-1:0]      verdict;
  logic [SLOT_W-1:0]         slot;

  // Stall chain
  assign rdy_out  = !v_out || results.ready;
  assign rdy_bnd  = !v_bnd || rdy_out;
  assign rdy_mul  = !v_mul || rdy_bnd;
  assign in_ready = rdy_mul;

  // Stage 1: bed offset = bed * step
  assign offs_next = OFFS_W'($signed({1'b0, in_data.bed})) * OFFS_W'(cfg.bed_step);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_mul <= 1'b0;
    end else if (rdy_mul) begin
      v_mul <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_mul && in_valid) begin
      offs       <= offs_next;
      late_mul   <= in_data.late;
      slot_mul   <= in_data.slot;
      ring_a_mul <= in_data.ring_a;
      ring_b_mul <= in_data.ring_b;
    end
  end

  // Stage 2: window bounds and 1-based rings
  assign lo_next = BOUND_W'($signed({1'b0, cfg.first_ring})) + BOUND_W'(offs);
  assign hi_next = lo_next + BOUND_W'($signed({1'b0, cfg.window_rings}))
                   - BOUND_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_bnd <= 1'b0;
    end else if (rdy_bnd) begin
      v_bnd <= v_mul;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_bnd && v_mul) begin
      lo       <= lo_next;
      hi       <= hi_next;
      ra1      <= BOUND_W'(ring_a_mul) + BOUND_W'(1);
      rb1      <= BOUND_W'(ring_b_mul) + BOUND_W'(1);
      late_bnd <= late_mul;
      slot_bnd <= slot_mul;
    end
  end

  // Stage 3: window test into the output register
  assign in_win = (ra1 >= lo) && (ra1 <= hi) && (rb1 >= lo) && (rb1 <= hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (rdy_out) begin
      v_out <= v_bnd;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && v_bnd) begin
      keep    <= !late_bnd && in_win;
      verdict <= late_bnd ? VERDICT_LATE : (in_win ? VERDICT_KEEP : VERDICT_RING);
      slot    <= slot_bnd;
    end
  end

  assign results.valid   = v_out;
  assign results.keep    = keep;
  assign results.verdict = verdict;
  assign results.slot    = slot;

`ifndef SYNTHESIS
  // Window spans exactly window_rings rings
  a_win_span: assert property (@(posedge clk) disable iff (rst)
    v_bnd |-> BOUND_W'(hi - lo + BOUND_W'(1)) == BOUND_W'(cfg.window_rings))
    else $error("window span does not match window_rings");

  // keep and verdict agree
  a_keep_code: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> results.keep == (results.verdict == VERDICT_KEEP))
    else $error("keep flag disagrees with verdict");

  // A stalled bounds stage keeps its item
  a_bnd_hold: assert property (@(posedge clk) disable iff (rst)
    v_bnd && !rdy_bnd |=> v_bnd && $stable(lo) && $stable(hi))
    else $error("bounds stage dropped a stalled item");
`endif

endmodule

// File: sv/multi_bed_coincidence_filter_unit.sv
`timescale 1ns / 1ps

// Multi-bed coincidence filter. Takes one coincidence event per clock when
// the output is not stalled and returns one result per event, in order. The
// pipeline is: one entry stage that forms the elapsed time, a 16-stage
// restoring divider that divides it by slot_seconds two quotient bits per
// stage, one stage for the past-last-slot test, a 4-stage bed remainder
// (slot mod bed_count, two bits per stage), then the bed-offset multiply,
// the window bounds and the registered window compare. Every stage holds its
// item when the next one is full, so events.ready falls only when the
// pipeline is full and results.ready is low. Configuration registers are
// read live by the stages, so a write also reaches events in flight; write
// them only while no event is in flight.

module multi_bed_coincidence_filter_unit
  import mbcf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  mbcf_event_if.sink            events,
  mbcf_result_if.source         results
);

  cfg_t cfg;
  logic quo_valid;
  logic quo_ready;
  quo_t quo_data;
  logic bed_valid;
  logic bed_ready;
  bed_t bed_data;

  // Configuration registers
  mbcf_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_wr_en),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Elapsed time and slot division
  mbcf_slot_div u_slot_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (events.valid),
    .in_ready  (events.ready),
    .in_ring_a (events.ring_a),
    .in_ring_b (events.ring_b),
    .in_time   (events.event_time),
    .cfg       (cfg),
    .out_valid (quo_valid),
    .out_ready (quo_ready),
    .out_data  (quo_data)
  );

  // Slot range test and bed index
  mbcf_bed_div u_bed_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (quo_valid),
    .in_ready  (quo_ready),
    .in_data   (quo_data),
    .cfg       (cfg),
    .out_valid (bed_valid),
    .out_ready (bed_ready),
    .out_data  (bed_data)
  );

  // Ring window test and result register
  mbcf_window u_window (
    .clk      (clk),
    .rst      (rst),
    .in_valid (bed_valid),
    .in_ready (bed_ready),
    .in_data  (bed_data),
    .cfg      (cfg),
    .results  (results)
  );

endmodule

// File: bench/multi_bed_coincidence_filter_unit_test.sv
`timescale 1ns / 1ps

module multi_bed_coincidence_filter_unit_test;
  import mbcf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;  // no register behind it
  localparam longint TIME_MAX  = 64'h7FFF_FFFF;
  localparam int     LONG_HOLD = 150;

  // Register copy used by the predictor
  typedef struct packed {
    logic [TIME_W-1:0]  first_time;
    logic [CYCLE_W-1:0] cycles;
    logic [BED_W-1:0]   beds;
    logic [FRING_W-1:0] first_ring;
    logic [WIN_W-1:0]   window;
    logic [OVL_W-1:0]   overlap;
    logic [SECS_W-1:0]  seconds;
  } bed_setup_t;

  typedef struct packed {
    logic                 keep;
    logic [VERDICT_W-1:0] verdict;
    logic [SLOT_W-1:0]    slot;
  } decision_t;

  typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_MOSTLY} sink_style_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mbcf_event_if  ev_ch ();
  mbcf_result_if res_ch ();

  multi_bed_coincidence_filter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .events    (ev_ch),
    .results   (res_ch)
  );

  bed_setup_t  setup;
  decision_t   pending_decisions[$];
  int unsigned error_count;
  int unsigned events_sent;
  int unsigned settings_used;
  int unsigned kept_count, late_count, outside_count;
  int unsigned input_stalls;
  int unsigned burst_left;
  bit          gaps_on;
  bit          hold_request;
  bit          draining;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin : watchdog
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Expected outcome of one event under the current register copy
  function automatic decision_t judge_event(input logic [RING_W-1:0] a,
                                            input logic [RING_W-1:0] b,
                                            input logic [TIME_W-1:0] t);
    longint    ra, rb, elapsed, total, slot, bed, bed_step, lo, hi;
    decision_t d;
    ra      = longint'(a) + 1;
    rb      = longint'(b) + 1;
    elapsed = longint'(t) - longint'(setup.first_time);
    total   = longint'(setup.beds) * longint'(setup.cycles);
    if (elapsed < 0) begin
      slot = 0;
    end else if (setup.seconds == 0) begin
      slot = total;  // slots never end
    end else begin
      slot = elapsed / longint'(setup.seconds);
    end
    d.slot = (slot > longint'(SLOT_MAX)) ? SLOT_MAX : SLOT_W'(slot);
    if (slot >= total) begin
      d.keep    = 1'b0;
      d.verdict = VERDICT_LATE;
      return d;
    end
    // window of this bed; step may be negative
    bed      = slot % longint'(setup.beds);
    bed_step = longint'(setup.window) - longint'(setup.overlap);
    lo       = longint'(setup.first_ring) + bed * bed_step;
    hi       = lo + longint'(setup.window) - 1;
    if (ra < lo || ra > hi || rb < lo || rb > hi) begin
      d.keep    = 1'b0;
      d.verdict = VERDICT_RING;
    end else begin
      d.keep    = 1'b1;
      d.verdict = VERDICT_KEEP;
    end
    return d;
  endfunction

  function automatic bed_setup_t make_setup(input int unsigned ft, input int unsigned cyc,
                                            input int unsigned beds, input int unsigned fr,
                                            input int unsigned win, input int unsigned ovl,
                                            input int unsigned secs);
    bed_setup_t s;
    s.first_time = TIME_W'(ft);
    s.cycles     = CYCLE_W'(cyc);
    s.beds       = BED_W'(beds);
    s.first_ring = FRING_W'(fr);
    s.window     = WIN_W'(win);
    s.overlap    = OVL_W'(ovl);
    s.seconds    = SECS_W'(secs);
    return s;
  endfunction

  // Mostly scan-like settings, plus extremes, raw random and zero registers
  function automatic bed_setup_t draw_setup();
    bed_setup_t  s;
    int unsigned style;
    style = $urandom_range(0, 9);
    case ($urandom_range(0, 3))
      0:       s.first_time = '0;
      1:       s.first_time = TIME_W'(TIME_MAX);
      default: s.first_time = TIME_W'($urandom_range(0, 32'h4000_0000));
    endcase
    s.cycles     = CYCLE_W'($urandom_range(1, 4));
    s.beds       = BED_W'($urandom_range(1, 6));
    s.first_ring = FRING_W'($urandom_range(1, 200));
    s.window     = WIN_W'($urandom_range(8, 160));
    s.overlap    = OVL_W'($urandom_range(0, s.window - 1));
    s.seconds    = SECS_W'($urandom_range(1, 300));
    if (style == 7) begin
      s.cycles     = $urandom_range(0, 1) ? CYCLE_W'(255) : CYCLE_W'(1);
      s.beds       = $urandom_range(0, 1) ? BED_W'(255) : BED_W'(1);
      s.first_ring = $urandom_range(0, 1) ? FRING_W'(1024) : FRING_W'(1);
      s.window     = $urandom_range(0, 1) ? WIN_W'(1024) : WIN_W'(1);
      s.overlap    = $urandom_range(0, 1) ? OVL_W'(1023) : OVL_W'(0);
      s.seconds    = $urandom_range(0, 1) ? SECS_W'(65535) : SECS_W'(1);
    end else if (style == 8) begin
      s.first_time = TIME_W'($urandom);
      s.cycles     = CYCLE_W'($urandom);
      s.beds       = BED_W'($urandom);
      s.first_ring = FRING_W'($urandom);
      s.window     = WIN_W'($urandom);
      s.overlap    = OVL_W'($urandom);
      s.seconds    = SECS_W'($urandom);
    end else if (style == 9) begin
      case ($urandom_range(0, 3))
        0:       s.seconds = '0;
        1:       s.beds    = '0;
        2:       s.cycles  = '0;
        default: s.window  = '0;
      endcase
    end
    return s;
  endfunction

  // 0-based ring near or inside the 1-based window [lo, lo+span-1]
  function automatic logic [RING_W-1:0] pick_ring(input longint lo, input longint span);
    longint      r;
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (span <= 0 || roll == 6) begin
      r = lo;
    end else if (roll < 6) begin
      r = lo + longint'($urandom_range(0, int'(span - 1)));
    end else if (roll == 7) begin
      r = lo + span - 1;
    end else if (roll == 8) begin
      r = lo - 1;
    end else begin
      r = lo + span;
    end
    if (r < 1 || r > 1024) return RING_W'($urandom);
    return RING_W'(r - 1);
  endfunction

  // Event aimed at a chosen slot and its bed window, or plain noise
  task automatic draw_event(output logic [RING_W-1:0] a, output logic [RING_W-1:0] b,
                            output logic [TIME_W-1:0] t);
    longint      total, s, when, lo;
    int unsigned pick;
    a     = RING_W'($urandom);
    b     = RING_W'($urandom);
    t     = TIME_W'($urandom);
    total = longint'(setup.beds) * longint'(setup.cycles);
    pick  = $urandom_range(0, 99);
    if (pick < 15 || total == 0) return;
    if (pick < 25) begin
      s = total + longint'($urandom_range(0, 2));
    end else begin
      s = longint'($urandom_range(0, int'(total - 1)));
    end
    if (setup.seconds == 0) begin
      when = longint'(setup.first_time) + longint'($urandom_range(0, 1000));
    end else begin
      when = longint'(setup.first_time) + s * longint'(setup.seconds)
           + longint'($urandom_range(0, setup.seconds - 1));
    end
    if (pick < 32) begin
      // before acquisition start: counts as the first slot
      s    = 0;
      when = longint'(setup.first_time) - longint'($urandom_range(1, 5000));
    end
    if (when >= 0 && when <= TIME_MAX) t = TIME_W'(when);
    lo = longint'(setup.first_ring)
       + (s % longint'(setup.beds)) * (longint'(setup.window) - longint'(setup.overlap));
    a = pick_ring(lo, longint'(setup.window));
    b = pick_ring(lo, longint'(setup.window));
  endtask

  // One item on the event channel; bursts with random gaps when enabled
  task automatic send_event(input logic [RING_W-1:0] a, input logic [RING_W-1:0] b,
                            input logic [TIME_W-1:0] t);
    ev_ch.valid      <= 1'b1;
    ev_ch.ring_a     <= a;
    ev_ch.ring_b     <= b;
    ev_ch.event_time <= t;
    @(posedge clk);
    while (!ev_ch.ready) @(posedge clk);
    pending_decisions = {pending_decisions, judge_event(a, b, t)};
    events_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        ev_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Stop sending and let every outstanding result come back
  task automatic wait_idle();
    ev_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Write all registers, plus the unused index which must change nothing
  task automatic apply_setup(input bed_setup_t s);
    write_reg(REG_FIRST_TIME, CFG_DATA_W'(s.first_time));
    write_reg(REG_CYCLE_COUNT, CFG_DATA_W'(s.cycles));
    write_reg(REG_BED_COUNT, CFG_DATA_W'(s.beds));
    write_reg(REG_FIRST_RING, CFG_DATA_W'(s.first_ring));
    write_reg(REG_WINDOW_RINGS, CFG_DATA_W'(s.window));
    write_reg(REG_OVERLAP_RINGS, CFG_DATA_W'(s.overlap));
    write_reg(REG_SLOT_SECONDS, CFG_DATA_W'(s.seconds));
    write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    cfg_wr_en <= 1'b0;
    setup = s;
    settings_used++;
  endtask

  // Registers as they come out of reset
  task automatic test_reset_values();
    send_event(10'd0, 10'd0, 31'd0);
    send_event(10'd1023, 10'd1023, 31'd59);
    send_event(10'd512, 10'd0, 31'd60);
    send_event(10'd1023, 10'd0, 31'h7FFF_FFFF);  // slot saturates
  endtask

  // Window borders across beds, early events and the last slot
  task automatic test_window_edges();
    wait_idle();
    apply_setup(make_setup(1000, 2, 3, 5, 10, 2, 100));
    send_event(10'd4, 10'd13, 31'd0);      // before start
    send_event(10'd3, 10'd4, 31'd1000);    // ring a below window
    send_event(10'd4, 10'd14, 31'd1099);   // ring b above window
    send_event(10'd20, 10'd29, 31'd1250);  // third bed, both borders
    send_event(10'd4, 10'd4, 31'd1350);    // second scan, first bed
    send_event(10'd25, 10'd25, 31'd1599);  // last slot
    send_event(10'd25, 10'd25, 31'd1600);  // one past last slot
  endtask

  // Zero slot length, zero beds, zero cycles, empty window
  task automatic test_zero_registers();
    wait_idle();
    apply_setup(make_setup(500, 3, 4, 1, 1024, 0, 0));
    send_event(10'd0, 10'd1023, 31'd400);
    send_event(10'd7, 10'd7, 31'd500);
    send_event(10'd7, 10'd7, 31'd90000);
    wait_idle();
    apply_setup(make_setup(0, 1, 0, 1, 1024, 0, 60));
    send_event(10'd1, 10'd2, 31'd6000);
    wait_idle();
    apply_setup(make_setup(0, 0, 5, 1, 1024, 0, 60));
    send_event(10'd1, 10'd2, 31'd0);
    wait_idle();
    apply_setup(make_setup(0, 1, 1, 1, 0, 0, 60));
    send_event(10'd0, 10'd0, 31'd30);
  endtask

  // Overlap wider than the window: beds walk downward
  task automatic test_negative_step();
    wait_idle();
    apply_setup(make_setup(0, 1, 4, 1000, 100, 1023, 10));
    send_event(10'd76, 10'd175, 31'd15);
    send_event(10'd0, 10'd0, 31'd25);
  endtask

  // Largest register values, then the largest slot total with one-second slots
  task automatic test_register_extremes();
    wait_idle();
    apply_setup(make_setup(32'h7FFF_FFFF, 255, 255, 2047, 2047, 1023, 65535));
    send_event(10'd1023, 10'd1023, 31'd0);
    send_event(10'd1023, 10'd1023, 31'h7FFF_FFFF);
    wait_idle();
    apply_setup(make_setup(0, 255, 255, 1024, 1, 0, 1));
    send_event(10'd1023, 10'd1023, 31'd0);
    send_event(10'd1023, 10'd1023, 31'd65024);
    send_event(10'd1023, 10'd1023, 31'd65025);
    send_event(10'd1023, 10'd1023, 31'd70000);
  endtask

  task automatic test_random_settings();
    logic [RING_W-1:0] a, b;
    logic [TIME_W-1:0] t;
    for (int n = 0; n < 45; n++) begin
      wait_idle();
      apply_setup(draw_setup());
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < 28; k++) begin
        draw_event(a, b, t);
        send_event(a, b, t);
      end
    end
  endtask

  // Long result hold-off while events keep coming back to back
  task automatic test_input_stall();
    logic [RING_W-1:0] a, b;
    logic [TIME_W-1:0] t;
    wait_idle();
    apply_setup(draw_setup());
    gaps_on      = 1'b0;
    hold_request = 1'b1;
    for (int k = 0; k < 70; k++) begin
      draw_event(a, b, t);
      send_event(a, b, t);
    end
    gaps_on = 1'b1;
  endtask

  // Result side: stall pattern of its own plus one long hold
  initial begin : result_sink
    sink_style_t style;
    int unsigned beat;
    int unsigned hold_count;
    style      = SINK_OPEN;
    beat       = 0;
    hold_count = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      beat++;
      if (beat % 48 == 0) style = sink_style_t'($urandom_range(0, 3));
      if (hold_request) begin
        hold_count++;
        if (hold_count >= LONG_HOLD) begin
          hold_request = 1'b0;
          hold_count   = 0;
        end
        res_ch.ready <= 1'b0;
      end else if (draining) begin
        res_ch.ready <= 1'b1;
      end else begin
        case (style)
          SINK_OPEN:   res_ch.ready <= 1'b1;
          SINK_COIN:   res_ch.ready <= ($urandom_range(0, 1) == 1);
          SINK_SPARSE: res_ch.ready <= (beat % 4 == 0);
          default:     res_ch.ready <= ($urandom_range(0, 99) < 85);
        endcase
      end
    end
  end

  // Compare each result with the oldest expected decision
  always @(posedge clk) begin : result_check
    decision_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_decisions.size() == 0) begin
        if (error_count < 40)
          $error("unexpected result: keep=%0d verdict=%0d slot=%0d",
                 res_ch.keep, res_ch.verdict, res_ch.slot);
        error_count++;
      end else begin
        want = pending_decisions.pop_front();
        case (want.verdict)
          VERDICT_KEEP: kept_count++;
          VERDICT_LATE: late_count++;
          default:      outside_count++;
        endcase
        if (res_ch.keep !== want.keep) begin
          if (error_count < 40)
            $error("keep: expected %0d, got %0d", want.keep, res_ch.keep);
          error_count++;
        end
        if (res_ch.verdict !== want.verdict) begin
          if (error_count < 40)
            $error("verdict: expected %0d, got %0d", want.verdict, res_ch.verdict);
          error_count++;
        end
        if (res_ch.slot !== want.slot) begin
          if (error_count < 40)
            $error("slot: expected %0d, got %0d", want.slot, res_ch.slot);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && ev_ch.valid && !ev_ch.ready) input_stalls++;
  end

  initial begin : sequencer
    rst              <= 1'b1;
    cfg_wr_en        <= 1'b0;
    cfg_index        <= REG_FIRST_TIME;
    cfg_data         <= '0;
    ev_ch.valid      <= 1'b0;
    ev_ch.ring_a     <= '0;
    ev_ch.ring_b     <= '0;
    ev_ch.event_time <= '0;
    setup         = make_setup(0, 1, 1, 1, 1024, 0, 60);
    error_count   = 0;
    events_sent   = 0;
    settings_used = 1;
    kept_count    = 0;
    late_count    = 0;
    outside_count = 0;
    input_stalls  = 0;
    burst_left    = 0;
    gaps_on       = 1'b1;
    hold_request  = 1'b0;
    draining      = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_window_edges();
    test_zero_registers();
    test_negative_step();
    test_register_extremes();
    test_random_settings();
    test_input_stall();

    // drain, then watch for stray results past the pipeline latency
    draining = 1'b1;
    wait_idle();
    repeat (40) @(posedge clk);
    if (pending_decisions.size() != 0) begin
      $error("%0d expected results never arrived", pending_decisions.size());
      error_count++;
    end

    $display("Run covered %0d events under %0d register settings: %0d kept, %0d late, %0d off-window.",
             events_sent, settings_used, kept_count, late_count, outside_count);
    $display("Event input was back-pressured for %0d cycles.", input_stalls);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
